### hw/rtl/sm83_pkg.sv
// shared operation codes, flag positions and item layouts for the sm83 alu
package sm83_pkg;

	localparam int OP_W = 5;

	localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
	localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
	localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
	localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
	localparam logic [OP_W-1:0] OP_AND   = 5'd4;
	localparam logic [OP_W-1:0] OP_XOR   = 5'd5;
	localparam logic [OP_W-1:0] OP_OR    = 5'd6;
	localparam logic [OP_W-1:0] OP_CP    = 5'd7;
	localparam logic [OP_W-1:0] OP_INC   = 5'd8;
	localparam logic [OP_W-1:0] OP_DEC   = 5'd9;
	localparam logic [OP_W-1:0] OP_RLC   = 5'd10;
	localparam logic [OP_W-1:0] OP_RL    = 5'd11;
	localparam logic [OP_W-1:0] OP_RRC   = 5'd12;
	localparam logic [OP_W-1:0] OP_RR    = 5'd13;
	localparam logic [OP_W-1:0] OP_SLA   = 5'd14;
	localparam logic [OP_W-1:0] OP_SRA   = 5'd15;
	localparam logic [OP_W-1:0] OP_SRL   = 5'd16;
	localparam logic [OP_W-1:0] OP_SWAP  = 5'd17;
	localparam logic [OP_W-1:0] OP_BIT   = 5'd18;
	localparam logic [OP_W-1:0] OP_SET   = 5'd19;
	localparam logic [OP_W-1:0] OP_RES   = 5'd20;
	localparam logic [OP_W-1:0] OP_DAA   = 5'd21;
	localparam logic [OP_W-1:0] OP_CPL   = 5'd22;
	localparam logic [OP_W-1:0] OP_CCF   = 5'd23;
	localparam logic [OP_W-1:0] OP_SCF   = 5'd24;
	localparam logic [OP_W-1:0] OP_ADDHL = 5'd25;
	localparam logic [OP_W-1:0] OP_ADDSP = 5'd26;

	// flag bit positions
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [7:0] DAA_LO = 8'h06;
	localparam logic [7:0] DAA_HI = 8'h60;
	localparam logic [7:0] DAA_LIM = 8'h99;

	// input payload, first field in the highest bits, last field (acc) in the lowest
	typedef struct packed {
		logic [3:0]        flags_in;
		logic signed [7:0] offset;
		logic [15:0]       word_b;
		logic [15:0]       word_a;
		logic [2:0]        bit_index;
		logic [7:0]        operand;
		logic [7:0]        acc;
	} in_item_t;

	// result payload, first field in the highest bits, last field (result_byte) in the lowest
	typedef struct packed {
		logic [3:0]  flags_out;
		logic [15:0] result_word;
		logic [7:0]  result_byte;
	} res_item_t;

	localparam int IN_W  = $bits(in_item_t);
	localparam int RES_W = $bits(res_item_t);

endpackage

### hw/rtl/sm83_alu_flags.sv
// top level: registered single-pass sm83 alu with z/n/h/c flags
//
// usage
//   slave side s_*: one transaction carries one alu request; s_tuser holds the
//   operation code, s_tdata the operands and the incoming flags
//   master side m_*: one transaction per request, in request order, with the
//   new byte, the 16-bit word result and the new flags
//   path: a request accepted on the slave side is registered in the input stage,
//   computed by shallow 8/16-bit logic and then registered in the result
//   register, whose valid bit drives m_tvalid
//   throughput: one request per cycle while m_tready is high; the only limit
//   is the single result register and the input stage, each holding one transaction
//   stall: when the receiver holds m_tready low, the result register keeps its
//   transaction, the input stage fills, and s_tready drops once both are full;
//   nothing is lost or duplicated
//   reset: arst_n low clears both valid bits at once; payload registers keep
//   whatever they held, no clearing pass is needed
//   unknown operation codes pass acc and the flags through unchanged
module sm83_alu_flags
	import sm83_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // acc, operand, bit_index, word_a, word_b, offset, flags_in
	input  logic [4:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // result_byte, result_word, flags_out
);

	// input stage
	logic            valid_s1;
	logic [OP_W-1:0] op_s1;
	in_item_t        item_s1;

	// result stage
	logic            valid_s2;
	res_item_t       res_s2;

	logic      s1_adv;
	logic      s2_free;
	logic      s_fire;
	res_item_t res_c;

	assign s2_free  = !valid_s2 || m_tready;
	assign s1_adv   = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1   <= s_tuser;
			item_s1 <= in_item_t'(s_tdata[IN_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(32-RES_W){1'b0}}, res_s2};

	// alu: everything for one request in one pass of shallow logic
	always_comb begin
		logic [7:0]  a;
		logic [7:0]  v;
		logic [3:0]  f;
		logic        cin;
		logic        cuse;
		logic [8:0]  add9;
		logic [4:0]  addh;
		logic [8:0]  sub9;
		logic [4:0]  subh;
		logic [7:0]  rb;
		logic [15:0] rw;
		logic [3:0]  fo;
		logic [7:0]  mask;
		logic [7:0]  adj;
		logic        dc;
		logic [16:0] hl17;
		logic [12:0] hl13;
		logic [4:0]  sph;
		logic [8:0]  spc;

		a    = item_s1.acc;
		v    = item_s1.operand;
		f    = item_s1.flags_in;
		cin  = f[FLAG_C];
		// carry in only for the with-carry forms
		cuse = ((op_s1 == OP_ADC) || (op_s1 == OP_SBC)) ? cin : 1'b0;
		add9 = {1'b0, a} + {1'b0, v} + {8'd0, cuse};
		addh = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cuse};
		sub9 = {1'b0, a} - {1'b0, v} - {8'd0, cuse};
		subh = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cuse};
		mask = 8'd1 << item_s1.bit_index;
		hl17 = {1'b0, item_s1.word_a} + {1'b0, item_s1.word_b};
		hl13 = {1'b0, item_s1.word_a[11:0]} + {1'b0, item_s1.word_b[11:0]};
		sph  = {1'b0, item_s1.word_a[3:0]} + {1'b0, item_s1.offset[3:0]};
		spc  = {1'b0, item_s1.word_a[7:0]} + {1'b0, item_s1.offset};

		// daa correction
		adj = 8'd0;
		dc  = 1'b0;
		if (f[FLAG_N]) begin
			if (f[FLAG_H]) adj = adj + DAA_LO;
			if (f[FLAG_C]) begin
				adj = adj + DAA_HI;
				dc  = 1'b1;
			end
		end else begin
			if (f[FLAG_H] || (a[3:0] > 4'h9)) adj = adj + DAA_LO;
			if (f[FLAG_C] || (a > DAA_LIM)) begin
				adj = adj + DAA_HI;
				dc  = 1'b1;
			end
		end

		rb = a;
		rw = 16'd0;
		fo = f;

		unique case (op_s1) inside
			OP_ADD, OP_ADC: begin
				rb = add9[7:0];
				fo = {rb == 8'd0, 1'b0, addh[4], add9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				rb = (op_s1 == OP_CP) ? a : sub9[7:0];
				fo = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
			end
			OP_AND: begin
				rb = a & v;
				fo = {rb == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				rb = a ^ v;
				fo = {rb == 8'd0, 3'b000};
			end
			OP_OR: begin
				rb = a | v;
				fo = {rb == 8'd0, 3'b000};
			end
			OP_INC: begin
				rb = v + 8'd1;
				fo = {rb == 8'd0, 1'b0, v[3:0] == 4'hF, cin};
			end
			OP_DEC: begin
				rb = v - 8'd1;
				fo = {rb == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
			end
			OP_RLC, OP_RL, OP_SLA: begin
				rb = {v[6:0], (op_s1 == OP_RLC) ? v[7] : ((op_s1 == OP_RL) ? cin : 1'b0)};
				fo = {rb == 8'd0, 2'b00, v[7]};
			end
			OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
				rb = {(op_s1 == OP_RRC) ? v[0] :
				      (op_s1 == OP_RR)  ? cin  :
				      (op_s1 == OP_SRA) ? v[7] : 1'b0, v[7:1]};
				fo = {rb == 8'd0, 2'b00, v[0]};
			end
			OP_SWAP: begin
				rb = {v[3:0], v[7:4]};
				fo = {rb == 8'd0, 3'b000};
			end
			OP_BIT: begin
				rb = v;
				fo = {(v & mask) == 8'd0, 1'b0, 1'b1, cin};
			end
			OP_SET: begin
				rb = v | mask;
			end
			OP_RES: begin
				rb = v & ~mask;
			end
			OP_DAA: begin
				rb = f[FLAG_N] ? (a - adj) : (a + adj);
				fo = {rb == 8'd0, f[FLAG_N], 1'b0, dc};
			end
			OP_CPL: begin
				rb = ~a;
				fo = {f[FLAG_Z], 1'b1, 1'b1, cin};
			end
			OP_CCF: begin
				fo = {f[FLAG_Z], 2'b00, ~cin};
			end
			OP_SCF: begin
				fo = {f[FLAG_Z], 2'b00, 1'b1};
			end
			OP_ADDHL: begin
				rb = 8'd0;
				rw = hl17[15:0];
				fo = {f[FLAG_Z], 1'b0, hl13[12], hl17[16]};
			end
			OP_ADDSP: begin
				rb = 8'd0;
				rw = item_s1.word_a + {{8{item_s1.offset[7]}}, item_s1.offset};
				fo = {2'b00, sph[4], spc[8]};
			end
			default: begin
				rb = a;
				rw = 16'd0;
				fo = f;
			end
		endcase

		res_c.result_byte = rb;
		res_c.result_word = rw;
		res_c.flags_out   = fo;
	end

	// an accepted request always occupies the input stage next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted request missing from input stage");

	// a request in the input stage with room downstream reaches the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s2_free |=> valid_s2)
		else $error("input stage advanced but result register empty");

	// a blocked input stage keeps its request
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(op_s1) && $stable(item_s1))
		else $error("stalled input stage lost its request");

	// only word operations produce a word, and they clear the byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.result_word != 16'd0) |-> (res_s2.result_byte == 8'd0))
		else $error("word result with nonzero byte result");

endmodule
